// ===== design/rgb_linear_crossfade_core_assert.svh =====
// ---------------------------------------------------------------------------
// rgb linear crossfade core assertion macros
// concurrent check helpers shared by the crossfade rtl
// ---------------------------------------------------------------------------
`ifndef RGB_LINEAR_CROSSFADE_CORE_ASSERT_SVH
`define RGB_LINEAR_CROSSFADE_CORE_ASSERT_SVH

// same-cycle implication
`define RLC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rlc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlc_pkg
// shared widths, codes and types of the rgb linear crossfade core
// ---------------------------------------------------------------------------
package rlc_pkg;

   localparam int COLOR_W    = 8;
   localparam int STEPS_W    = 8;
   localparam int TIME_W     = 16;
   localparam int IDX_W      = 9;
   localparam int DELTA_W    = 9;
   localparam int ELAPSED_W  = 17;
   localparam int DIV_W      = 17;
   localparam int CNT_W      = $clog2(DIV_W + 1);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int NUM_CH     = 3;
   localparam int CH_W       = 2;

   localparam logic [STEPS_W-1:0]   NUM_STEPS_RESET = 8'd30;
   localparam logic [TIME_W-1:0]    TIME_RESET      = 16'd500;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = 17'h1FFFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_STEPS       = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSITION_TIME = 1'b1;

   // word function codes
   localparam logic FUNC_SET  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef logic [COLOR_W-1:0]        color_type;
   typedef logic signed [DELTA_W-1:0] delta_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [STEPS_W-1:0]   divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_W-1:0]     quotient;
      logic [STEPS_W-1:0]   remainder;
   } div_sts_type;

endpackage
`default_nettype wire

// ===== design/rlc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlc_div
// bit-serial restoring divider, one quotient bit per clock
// ---------------------------------------------------------------------------
module rlc_div (
   input  wire                  clock,
   input  wire                  reset,
   input  rlc_pkg::div_cmd_type cmd,
   output rlc_pkg::div_sts_type sts
);
   import rlc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [STEPS_W-1:0]   rem_ff, rem_in;
   logic [STEPS_W-1:0]   dvs_ff, dvs_in;

   logic [STEPS_W:0]     trial;
   logic [STEPS_W:0]     trial_sub;
   logic                 fits;

   // partial remainder shifted left with the next dividend bit
   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign fits      = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? trial_sub[STEPS_W-1:0] : trial[STEPS_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign sts.done      = done_ff;
   assign sts.quotient  = quo_ff;
   assign sts.remainder = rem_ff;

endmodule
`default_nettype wire

// ===== design/rlc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlc_step
// one channel fade step: quotient plus a spread unit from the remainder
// ---------------------------------------------------------------------------
module rlc_step (
   input  rlc_pkg::color_type           color_cur,
   input  rlc_pkg::delta_type           quotient,
   input  rlc_pkg::delta_type           remainder,
   input  wire [rlc_pkg::STEPS_W-1:0]   mod_value,
   output rlc_pkg::color_type           color_next,
   output logic [rlc_pkg::STEPS_W-1:0]  rem_mag
);
   import rlc_pkg::*;

   delta_type   rem_neg;
   logic        extra_en;
   color_type   extra;

   assign rem_neg = -remainder;
   assign rem_mag = remainder[DELTA_W-1] ? rem_neg[STEPS_W-1:0] : remainder[STEPS_W-1:0];

   // (k*|r|) mod n below |r| means the running share crossed a whole unit
   assign extra_en = (mod_value < rem_mag);

   always_comb begin
      if (!extra_en) begin
         extra = '0;
      end else if (quotient[DELTA_W-1] || remainder[DELTA_W-1]) begin
         extra = '1;
      end else begin
         extra = COLOR_W'(1);
      end
   end

   assign color_next = color_cur + quotient[COLOR_W-1:0] + extra;

endmodule
`default_nettype wire

// ===== design/rgb_linear_crossfade_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rgb_linear_crossfade_core
// fades a 24-bit rgb color toward a target in a set number of steps
// ---------------------------------------------------------------------------
// usage
//   req channel: one word per set-target command (func 0) or millisecond tick
//   (func 1); a word is taken when req_valid is high and req_stall is low
//   rsp channel: current color and fading flag after a jump or a fade step
//   csr port: csr_wr_en writes num_steps (index 0) or transition time (index 1)
// division and sequencing
//   all division runs through one bit-serial divider of 17 bits
//   jump set (zero time): goes through the emit state to rsp_valid, no division
//   fade set: three channel divisions, no rsp word
//   tick while idle: no division; tick while fading: one division for the step
//   threshold, plus three channel step divisions when a step fires
//   one word is in flight at a time; req_stall is high while it is worked on
// reset
//   synchronous; color, fade state, elapsed counter and registers return to
//   black, not fading, 30 steps and 500 ms; no rsp word is pending
// stall
//   a pending rsp word holds while rsp_stall is high; a new word is still
//   accepted, and a result that needs the output register waits for it
// ---------------------------------------------------------------------------
`include "rgb_linear_crossfade_core_assert.svh"

module rgb_linear_crossfade_core (
   input  wire                              clock,
   input  wire                              reset,
   // request channel
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_func,
   input  wire [rlc_pkg::COLOR_W-1:0]       req_red_in,
   input  wire [rlc_pkg::COLOR_W-1:0]       req_green_in,
   input  wire [rlc_pkg::COLOR_W-1:0]       req_blue_in,
   // response channel
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [rlc_pkg::COLOR_W-1:0]      rsp_red_out,
   output logic [rlc_pkg::COLOR_W-1:0]      rsp_green_out,
   output logic [rlc_pkg::COLOR_W-1:0]      rsp_blue_out,
   output logic                             rsp_fading,
   // register write port
   input  wire                              csr_wr_en,
   input  wire [rlc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [rlc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rlc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SET_LOAD,
      S_SET_WAIT,
      S_THR_WAIT,
      S_STEP_LOAD,
      S_STEP_WAIT,
      S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [CH_W-1:0]        ch_ff, ch_in;

   // fade state
   color_type              color_ff [NUM_CH];
   color_type              color_in [NUM_CH];
   delta_type              quo_ff [NUM_CH];
   delta_type              quo_in [NUM_CH];
   delta_type              rem_ff [NUM_CH];
   delta_type              rem_in [NUM_CH];
   color_type              tgt_ff [NUM_CH];
   color_type              tgt_in [NUM_CH];
   logic [IDX_W-1:0]       step_idx_ff, step_idx_in;
   logic                   in_fade_ff, in_fade_in;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in;

   // registers
   logic [STEPS_W-1:0]     num_steps_ff, num_steps_in;
   logic [TIME_W-1:0]      ttime_ff, ttime_in;

   // divider command and output word
   div_cmd_type            div_cmd_ff, div_cmd_in;
   div_sts_type            div_sts;
   logic                   rsp_valid_ff, rsp_valid_in;
   color_type              rsp_red_ff, rsp_red_in;
   color_type              rsp_green_ff, rsp_green_in;
   color_type              rsp_blue_ff, rsp_blue_in;
   logic                   rsp_fading_ff, rsp_fading_in;

   logic [STEPS_W-1:0]     n_eff;
   logic                   req_take;
   logic                   rsp_free;

   // set path: signed channel difference as sign and magnitude
   logic [DELTA_W-1:0]     set_diff;
   logic [DELTA_W-1:0]     set_diff_neg;
   logic                   set_neg;
   logic [COLOR_W-1:0]     set_mag;
   logic [DELTA_W-1:0]     set_q_mag;
   logic [DELTA_W-1:0]     set_r_mag;

   // step path
   color_type              step_color;
   logic [STEPS_W-1:0]     step_rem_mag;
   logic [DIV_W-1:0]       step_prod;
   logic [IDX_W-1:0]       step_idx_nxt;

   // a step count of zero behaves as one
   assign n_eff = (num_steps_ff == '0) ? STEPS_W'(1) : num_steps_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign set_diff     = {1'b0, tgt_ff[ch_ff]} - {1'b0, color_ff[ch_ff]};
   assign set_diff_neg = -set_diff;
   assign set_neg      = set_diff[DELTA_W-1];
   assign set_mag      = set_neg ? set_diff_neg[COLOR_W-1:0] : set_diff[COLOR_W-1:0];
   assign set_q_mag    = {1'b0, div_sts.quotient[COLOR_W-1:0]};
   assign set_r_mag    = {1'b0, div_sts.remainder};

   // k * |r| feeds the remainder test of the spread term
   assign step_prod    = DIV_W'(step_idx_ff) * DIV_W'(step_rem_mag);
   assign step_idx_nxt = step_idx_ff + IDX_W'(1);

   rlc_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd_ff),
      .sts   (div_sts)
   );

   rlc_step u_step (
      .color_cur  (color_ff[ch_ff]),
      .quotient   (quo_ff[ch_ff]),
      .remainder  (rem_ff[ch_ff]),
      .mod_value  (div_sts.remainder),
      .color_next (step_color),
      .rem_mag    (step_rem_mag)
   );

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      color_in      = color_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      tgt_in        = tgt_ff;
      step_idx_in   = step_idx_ff;
      in_fade_in    = in_fade_ff;
      elapsed_in    = elapsed_ff;
      num_steps_in  = num_steps_ff;
      ttime_in      = ttime_ff;
      div_cmd_in    = div_cmd_ff;
      div_cmd_in.start = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_red_in    = rsp_red_ff;
      rsp_green_in  = rsp_green_ff;
      rsp_blue_in   = rsp_blue_ff;
      rsp_fading_in = rsp_fading_ff;

      // register writes are for the user to make only while no word is in flight; the block does not enforce it
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_STEPS:       num_steps_in = csr_wdata[STEPS_W-1:0];
            CSR_TRANSITION_TIME: ttime_in     = csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_func == FUNC_SET) begin
                  tgt_in[0] = req_red_in;
                  tgt_in[1] = req_green_in;
                  tgt_in[2] = req_blue_in;
                  if (ttime_ff == '0) begin
                     // jump straight to the target, ends any fade
                     color_in[0] = req_red_in;
                     color_in[1] = req_green_in;
                     color_in[2] = req_blue_in;
                     in_fade_in  = 1'b0;
                     state_in    = S_EMIT;
                  end else begin
                     ch_in    = '0;
                     state_in = S_SET_LOAD;
                  end
               end else begin
                  // elapsed counts on every tick, saturating
                  if (elapsed_ff != ELAPSED_MAX) begin
                     elapsed_in = elapsed_ff + ELAPSED_W'(1);
                  end
                  if (in_fade_ff) begin
                     div_cmd_in.start    = 1'b1;
                     div_cmd_in.dividend = DIV_W'(ttime_ff);
                     div_cmd_in.divisor  = n_eff;
                     state_in            = S_THR_WAIT;
                  end
               end
            end
         end
         S_SET_LOAD: begin
            div_cmd_in.start    = 1'b1;
            div_cmd_in.dividend = DIV_W'(set_mag);
            div_cmd_in.divisor  = n_eff;
            state_in            = S_SET_WAIT;
         end
         S_SET_WAIT: begin
            if (div_sts.done) begin
               // truncating division: quotient and remainder take the sign
               quo_in[ch_ff] = set_neg ? delta_type'(-set_q_mag) : delta_type'(set_q_mag);
               rem_in[ch_ff] = set_neg ? delta_type'(-set_r_mag) : delta_type'(set_r_mag);
               if (ch_ff == CH_W'(NUM_CH - 1)) begin
                  step_idx_in = IDX_W'(1);
                  in_fade_in  = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  ch_in    = ch_ff + CH_W'(1);
                  state_in = S_SET_LOAD;
               end
            end
         end
         S_THR_WAIT: begin
            if (div_sts.done) begin
               if (elapsed_ff > div_sts.quotient) begin
                  elapsed_in = '0;
                  ch_in      = '0;
                  state_in   = S_STEP_LOAD;
               end else begin
                  // live step count may have dropped under the index
                  if (step_idx_ff > IDX_W'(n_eff)) begin
                     in_fade_in = 1'b0;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         S_STEP_LOAD: begin
            div_cmd_in.start    = 1'b1;
            div_cmd_in.dividend = step_prod;
            div_cmd_in.divisor  = n_eff;
            state_in            = S_STEP_WAIT;
         end
         S_STEP_WAIT: begin
            if (div_sts.done) begin
               color_in[ch_ff] = step_color;
               if (ch_ff == CH_W'(NUM_CH - 1)) begin
                  step_idx_in = step_idx_nxt;
                  in_fade_in  = !(step_idx_nxt > IDX_W'(n_eff));
                  state_in    = S_EMIT;
               end else begin
                  ch_in    = ch_ff + CH_W'(1);
                  state_in = S_STEP_LOAD;
               end
            end
         end
         S_EMIT: begin
            // wait for the output register to drain
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_red_in    = color_ff[0];
               rsp_green_in  = color_ff[1];
               rsp_blue_in   = color_ff[2];
               rsp_fading_in = in_fade_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      tgt_ff        <= tgt_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_green_ff  <= rsp_green_in;
      rsp_blue_ff   <= rsp_blue_in;
      rsp_fading_ff <= rsp_fading_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         for (int i = 0; i < NUM_CH; i++) begin
            color_ff[i] <= '0;
            quo_ff[i]   <= '0;
            rem_ff[i]   <= '0;
         end
         step_idx_ff  <= '0;
         in_fade_ff   <= 1'b0;
         elapsed_ff   <= '0;
         num_steps_ff <= NUM_STEPS_RESET;
         ttime_ff     <= TIME_RESET;
         div_cmd_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         color_ff     <= color_in;
         quo_ff       <= quo_in;
         rem_ff       <= rem_in;
         step_idx_ff  <= step_idx_in;
         in_fade_ff   <= in_fade_in;
         elapsed_ff   <= elapsed_in;
         num_steps_ff <= num_steps_in;
         ttime_ff     <= ttime_in;
         div_cmd_ff   <= div_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out  = rsp_blue_ff;
   assign rsp_fading    = rsp_fading_ff;

   // divider results only come back while the sequencer waits for one
   `RLC_ASSERT_IMPLY(a_div_done_waiting, clock, reset, div_sts.done, (state_ff == S_SET_WAIT) || (state_ff == S_THR_WAIT) || (state_ff == S_STEP_WAIT), "divider done outside a wait state")

   // a zero-time set goes straight to the output word
   `RLC_ASSERT_NEXT(a_jump_emits, clock, reset, req_take && (req_func == FUNC_SET) && (ttime_ff == '0), state_ff == S_EMIT, "jump set did not go to emit")

   // an active fade always has a one-based step index
   `RLC_ASSERT_IMPLY(a_fade_index, clock, reset, in_fade_ff, step_idx_ff != '0, "fade active with zero step index")

endmodule
`default_nettype wire
